### hw/rtl/tps_pkg.sv
`default_nettype none
package tps_pkg;

  // table depth and derived widths
  localparam int MAX_POINTS = 64;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // datapath widths
  localparam int TERM_W = 48;
  localparam int ACC_W  = 58;

  // ln(2) in Q16
  localparam logic [15:0] LN2_Q16 = 16'd45426;

  // configuration register indexes
  localparam logic [7:0] CFG_NUM_POINTS   = 8'd0;
  localparam logic [7:0] CFG_AFFINE_CONST = 8'd1;
  localparam logic [7:0] CFG_AFFINE_X     = 8'd2;
  localparam logic [7:0] CFG_AFFINE_Y     = 8'd3;

  // input word kinds
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // one stored control point
  typedef struct packed {
    logic signed [31:0] w;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } tps_entry_t;

  // kernel pipeline status toward the sequencer
  typedef struct packed {
    logic                     busy;
    logic                     term_valid;
    logic signed [TERM_W-1:0] term;
  } tps_kern_t;

  // round(65536*log2(1+i/16))
  function automatic logic [16:0] log2_frac(input logic [4:0] i);
    logic [16:0] r;
    case (i)
      5'd0:  r = 17'd0;
      5'd1:  r = 17'd5732;
      5'd2:  r = 17'd11136;
      5'd3:  r = 17'd16248;
      5'd4:  r = 17'd21098;
      5'd5:  r = 17'd25711;
      5'd6:  r = 17'd30109;
      5'd7:  r = 17'd34312;
      5'd8:  r = 17'd38336;
      5'd9:  r = 17'd42196;
      5'd10: r = 17'd45904;
      5'd11: r = 17'd49472;
      5'd12: r = 17'd52911;
      5'd13: r = 17'd56229;
      5'd14: r = 17'd59434;
      5'd15: r = 17'd62534;
      5'd16: r = 17'd65536;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/tps_point_mem.sv
`default_nettype none
module tps_point_mem
  import tps_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [PT_AW-1:0] wr_addr,
  input  wire tps_entry_t       wr_data,
  input  wire logic             rd_en,
  input  wire logic [PT_AW-1:0] rd_addr,
  output tps_entry_t            rd_data,
  output logic                  rd_valid
);

  tps_entry_t mem [MAX_POINTS];
  tps_entry_t rd_data_r;
  logic       rd_valid_r;

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_en;
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_valid = rd_valid_r;

endmodule
`default_nettype wire

### hw/rtl/tps_kernel.sv
`default_nettype none
module tps_kernel
  import tps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               pt_valid,
  input  wire tps_entry_t         pt,
  input  wire logic signed [15:0] qx,
  input  wire logic signed [15:0] qy,
  output tps_kern_t               kern
);

  logic [9:1] v_r;

  // stage 1: squared differences
  logic signed [16:0] dx, dy;
  logic signed [33:0] sqx_full, sqy_full;
  logic [32:0]        sqx_r, sqy_r;
  logic signed [31:0] w1_r;
  assign dx = {qx[15], qx} - {pt.x[15], pt.x};
  assign dy = {qy[15], qy} - {pt.y[15], pt.y};
  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;
  always_ff @(posedge clk) begin
    sqx_r <= sqx_full[32:0];
    sqy_r <= sqy_full[32:0];
    w1_r  <= pt.w;
  end

  // stage 2: d2
  logic [33:0]        d2_2_r;
  logic signed [31:0] w2_r;
  always_ff @(posedge clk) begin
    d2_2_r <= {1'b0, sqx_r} + {1'b0, sqy_r};
    w2_r   <= w1_r;
  end

  // stage 3: leading one and 12-bit mantissa
  logic [5:0]  lead;
  logic [33:0] nrm;
  logic [5:0]  e3_r;
  logic [11:0] m3_r;
  logic [33:0] d2_3_r;
  logic        z3_r;
  logic signed [31:0] w3_r;
  always_comb begin
    lead = 6'd0;
    for (int i = 0; i < 34; i++) begin
      if (d2_2_r[i]) lead = 6'(i);
    end
  end
  assign nrm = d2_2_r << (6'd33 - lead);
  always_ff @(posedge clk) begin
    e3_r   <= lead;
    m3_r   <= nrm[32:21];
    d2_3_r <= d2_2_r;
    z3_r   <= (d2_2_r == 34'd0);
    w3_r   <= w2_r;
  end

  // stage 4: log2 of d2/256 in Q16
  logic [4:0]  ix;
  logic [16:0] t0, t1, dt, frac;
  logic [24:0] ip;
  logic signed [23:0] l2_4_r;
  logic [33:0] d2_4_r;
  logic        z4_r;
  logic signed [31:0] w4_r;
  assign ix   = {1'b0, m3_r[11:8]};
  assign t0   = log2_frac(ix);
  assign t1   = log2_frac(ix + 5'd1);
  assign dt   = t1 - t0;
  assign ip   = dt * {9'd0, m3_r[7:0]};
  assign frac = t0 + ip[24:8];
  always_ff @(posedge clk) begin
    l2_4_r <= $signed(24'({e3_r, 16'd0}) + 24'(frac)) - 24'sd524288;
    d2_4_r <= d2_3_r;
    z4_r   <= z3_r;
    w4_r   <= w3_r;
  end

  // stage 5: ln = log2 * ln2, magnitude truncated
  logic [22:0] lmag;
  logic [38:0] lp;
  logic [22:0] nmag5_r;
  logic        nneg5_r;
  logic [33:0] d2_5_r;
  logic        z5_r;
  logic signed [31:0] w5_r;
  assign lmag = l2_4_r[23] ? 23'(-l2_4_r) : 23'(l2_4_r);
  assign lp   = lmag * LN2_Q16;
  always_ff @(posedge clk) begin
    nmag5_r <= lp[38:16];
    nneg5_r <= l2_4_r[23];
    d2_5_r  <= d2_4_r;
    z5_r    <= z4_r;
    w5_r    <= w4_r;
  end

  // stage 6: d2 * |ln| as two partial products
  logic [39:0] pl6_r, ph6_r;
  logic        nneg6_r, z6_r;
  logic signed [31:0] w6_r;
  always_ff @(posedge clk) begin
    pl6_r   <= d2_5_r[16:0] * nmag5_r;
    ph6_r   <= d2_5_r[33:17] * nmag5_r;
    nneg6_r <= nneg5_r;
    z6_r    <= z5_r;
    w6_r    <= w5_r;
  end

  // stage 7: combine, >> 9
  logic [56:0] kfull;
  logic [47:0] mk7_r;
  logic        nneg7_r, z7_r;
  logic signed [31:0] w7_r;
  assign kfull = {ph6_r, 17'd0} + 57'(pl6_r);
  always_ff @(posedge clk) begin
    mk7_r   <= kfull[56:9];
    nneg7_r <= nneg6_r;
    z7_r    <= z6_r;
    w7_r    <= w6_r;
  end

  // stage 8: |w| * |K| as two partial products
  logic [31:0] mw;
  logic [55:0] ql8_r, qh8_r;
  logic        neg8_r, z8_r;
  assign mw = w7_r[31] ? 32'(-w7_r) : 32'(w7_r);
  always_ff @(posedge clk) begin
    ql8_r  <= mw * mk7_r[23:0];
    qh8_r  <= mw * mk7_r[47:24];
    neg8_r <= w7_r[31] ^ nneg7_r;
    z8_r   <= z7_r;
  end

  // stage 9: >> 16, clamp to 2^46, sign
  logic [79:0] qfull;
  logic [63:0] qmag;
  logic [46:0] tmag;
  logic signed [TERM_W-1:0] term9_r;
  assign qfull = {qh8_r, 24'd0} + 80'(ql8_r);
  assign qmag  = qfull[79:16];
  assign tmag  = (qmag > 64'h4000_0000_0000) ? 47'h4000_0000_0000 : qmag[46:0];
  always_ff @(posedge clk) begin
    if (z8_r) begin
      term9_r <= '0;
    end else if (neg8_r) begin
      term9_r <= -$signed({1'b0, tmag});
    end else begin
      term9_r <= $signed({1'b0, tmag});
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[8:1], pt_valid};
    end
  end

  assign kern.busy       = pt_valid | (|v_r);
  assign kern.term_valid = v_r[9];
  assign kern.term       = term9_r;

endmodule
`default_nettype wire

### hw/rtl/thin_plate_spline_evaluate.sv
// Thin-plate spline evaluator: one table entry per cycle into a 9-stage kernel pipeline.
// Write word: stored at acceptance; the block stays idle and ready for the next word.
// Query word: one kernel term per entry over count = min(num_points, 64) table entries;
// the next word is taken in the cycle after the result loads.
// A result held by out_tready low keeps the block in its done state and blocks input.
// Synchronous active-low reset clears control and config (num_points = 3); table not reset.
`default_nettype none
module thin_plate_spline_evaluate
  import tps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // entry_index, coord_x, coord_y, weight, zero pad
  input  wire logic        in_tuser,   // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // value
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_SUM   = 6'b000100,
    ST_SWEEP = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [6:0]         num_points_r;
  logic signed [31:0] aff_c_r, aff_x_r, aff_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r <= 7'd3;
      aff_c_r      <= '0;
      aff_x_r      <= '0;
      aff_y_r      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NUM_POINTS:   num_points_r <= cfg_data[6:0];
        CFG_AFFINE_CONST: aff_c_r      <= cfg_data;
        CFG_AFFINE_X:     aff_x_r      <= cfg_data;
        CFG_AFFINE_Y:     aff_y_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // input word fields
  logic [5:0]         f_idx;
  logic signed [15:0] f_x, f_y;
  logic signed [31:0] f_w;
  logic               in_acc;
  assign f_idx  = in_tdata[5:0];
  assign f_x    = in_tdata[21:6];
  assign f_y    = in_tdata[37:22];
  assign f_w    = in_tdata[69:38];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;

  // point table
  logic             wr_en, rd_en, rd_valid;
  logic [PT_AW-1:0] rd_addr;
  tps_entry_t       wr_data, rd_data;
  tps_kern_t        kern;

  assign wr_en   = in_acc && (in_tuser == FUNC_WRITE) && (32'(f_idx) < MAX_POINTS);
  assign wr_data = '{w: f_w, y: f_y, x: f_x};

  tps_point_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (PT_AW'(f_idx)),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  // query registers
  logic signed [15:0] qx_r, qy_r;
  logic signed [47:0] px_r, py_r;
  logic [CNT_W-1:0]   cnt_r, idx_r;
  logic signed [ACC_W-1:0] acc_r;

  tps_kernel u_kern (
    .clk      (clk),
    .rst_n    (rst_n),
    .pt_valid (rd_valid),
    .pt       (rd_data),
    .qx       (qx_r),
    .qy       (qy_r),
    .kern     (kern)
  );

  assign rd_en   = (state_r == ST_SWEEP);
  assign rd_addr = idx_r[PT_AW-1:0];

  // output register
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_load;
  logic [31:0] sat;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  always_comb begin
    if (acc_r > ACC_W'(64'sh7FFF_FFFF)) begin
      sat = 32'h7FFF_FFFF;
    end else if (acc_r < -ACC_W'(64'sh8000_0000)) begin
      sat = 32'h8000_0000;
    end else begin
      sat = acc_r[31:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && in_tuser == FUNC_QUERY) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_SUM;
      ST_SUM:   state_nxt = (cnt_r == '0) ? ST_DRAIN : ST_SWEEP;
      ST_SWEEP: if (idx_r == cnt_r - CNT_W'(1)) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!kern.busy && !rd_valid) state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      qx_r <= f_x;
      qy_r <= f_y;
    end
    if (state_r == ST_MUL) begin
      px_r <= aff_x_r * qx_r;
      py_r <= aff_y_r * qy_r;
      cnt_r <= (32'(num_points_r) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                : CNT_W'(num_points_r);
    end
    if (state_r == ST_SUM) begin
      acc_r <= ACC_W'(aff_c_r) + ACC_W'(px_r >>> 4) + ACC_W'(py_r >>> 4);
      idx_r <= '0;
    end else if (kern.term_valid) begin
      acc_r <= acc_r + ACC_W'(kern.term);
    end
    if (state_r == ST_SWEEP) begin
      idx_r <= idx_r + CNT_W'(1);
    end
    if (out_load) begin
      out_data_r <= sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !kern.busy)
    else $error("input taken while kernel busy");
  a_rd_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid |-> ($past(state_r) == ST_SWEEP))
    else $error("table read outside sweep");
  a_term_window: assert property (@(posedge clk) disable iff (!rst_n)
    kern.term_valid |-> (state_r == ST_SWEEP || state_r == ST_DRAIN))
    else $error("term outside sweep/drain");
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (!kern.busy && !rd_valid))
    else $error("result with terms in flight");

endmodule
`default_nettype wire
